>>> design/tscu_pkg.sv
// Package for the tetrahedron shape check unit: datapath widths, result codes,
// the control word that travels with each pipeline stage and small helpers.
// Depends on nothing; every other design file imports it.
package tscu_pkg;

  localparam int CW    = 32;   // input coordinate width
  localparam int NCRD  = 12;   // coordinates in one input transaction
  localparam int DW    = 33;   // edge vector component width
  localparam int PW    = 66;   // product of a pair of edge components
  localparam int KW    = 67;   // cofactor width
  localparam int DETW  = 102;  // determinant width (signed)
  localparam int TRW   = 136;  // squared Frobenius sum width
  localparam int BLW   = 7;    // bit length of the determinant
  localparam int DNW   = 32;   // normalised determinant
  localparam int TNW   = 76;   // normalised trace
  localparam int T2W   = 152;
  localparam int D4W   = 128;
  localparam int T3W   = 228;
  localparam int NW    = 147;  // quotient width, also the number of divider steps
  localparam int QW    = 49;   // cube root width, also the number of root steps
  localparam int CBW   = 150;  // scratch width inside a root step
  localparam int BADW  = 48;
  localparam int LIMW  = 32;
  localparam int BAD_FRAC = 16;
  localparam int IN_TDATA_W  = NCRD * CW;
  localparam int OUT_TDATA_W = 56;

  localparam logic [QW-1:0] Q_CAP      = QW'((64'd1 << 48) - 64'd1 + 64'd196608);
  localparam logic [QW-1:0] BAD_OFFSET = QW'(64'd196608);
  localparam logic [LIMW-1:0] LIMIT_RESET = LIMW'(100000000);

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_FLIP = 2'd1,
    VERDICT_BAD  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic vld;   // stage holds an item
    logic dpos;  // determinant is strictly positive
    logic cap;   // root result is saturated
  } tscu_ctl_t;

  // Number of significant bits in a non-negative determinant.
  function automatic logic [BLW-1:0] bit_len(input logic [DETW-1:0] v);
    logic [BLW-1:0] n;
    n = '0;
    for (int i = 0; i < DETW; i++) begin
      if (v[i]) n = BLW'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> design/tscu_front.sv
// Front end of the tetrahedron shape check: edge vectors, cofactors, the
// determinant and the squared Frobenius sum of the cofactor matrix.
// Seven register stages; depends on tscu_pkg.
module tscu_front import tscu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [IN_TDATA_W-1:0]   crd_i,
  output tscu_ctl_t               ctl_o,
  output logic signed [DETW-1:0]  det_o,
  output logic [TRW-1:0]          tr_o
);

  logic [6:0] vld_r;

  logic signed [DW-1:0]   l_r [3][3];
  logic signed [DW-1:0]   l_nxt [3][3];
  logic signed [DW-1:0]   r2_r [3];
  logic signed [DW-1:0]   r3_r [3];
  logic signed [PW-1:0]   pa_r [9];
  logic signed [PW-1:0]   pb_r [9];
  logic signed [PW-1:0]   pa_nxt [9];
  logic signed [PW-1:0]   pb_nxt [9];
  logic signed [KW-1:0]   k_r [9];
  logic signed [KW-1:0]   k_nxt [9];
  logic signed [67:0]     dl_r [3];
  logic signed [65:0]     dh_r [3];
  logic signed [65:0]     hh_r [9];
  logic signed [67:0]     hl_r [9];
  logic [67:0]            ll_r [9];
  logic signed [67:0]     dl_nxt [3];
  logic signed [65:0]     dh_nxt [3];
  logic signed [65:0]     hh_nxt [9];
  logic signed [67:0]     hl_nxt [9];
  logic [67:0]            ll_nxt [9];
  logic [DETW-1:0]        dt_r [3];
  logic [TRW-1:0]         sq_r [9];
  logic [DETW-1:0]        det6_r;
  logic [TRW-1:0]         tg_r [3];
  logic [DETW-1:0]        det7_r;
  logic [TRW-1:0]         tr7_r;
  logic                   dpos7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  // Edge vectors: column j is vertex j minus the candidate vertex.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        l_nxt[i][j] = DW'($signed(crd_i[(3 + 3 * j + i) * CW +: CW]))
                    - DW'($signed(crd_i[i * CW +: CW]));
      end
    end
  end

  // Products for the nine 2x2 minors.
  always_comb begin
    pa_nxt[0] = l_r[1][1] * l_r[2][2];  pb_nxt[0] = l_r[1][2] * l_r[2][1];
    pa_nxt[1] = l_r[0][2] * l_r[2][1];  pb_nxt[1] = l_r[0][1] * l_r[2][2];
    pa_nxt[2] = l_r[0][1] * l_r[1][2];  pb_nxt[2] = l_r[1][1] * l_r[0][2];
    pa_nxt[3] = l_r[2][0] * l_r[1][2];  pb_nxt[3] = l_r[1][0] * l_r[2][2];
    pa_nxt[4] = l_r[0][0] * l_r[2][2];  pb_nxt[4] = l_r[0][2] * l_r[2][0];
    pa_nxt[5] = l_r[1][0] * l_r[0][2];  pb_nxt[5] = l_r[0][0] * l_r[1][2];
    pa_nxt[6] = l_r[1][0] * l_r[2][1];  pb_nxt[6] = l_r[2][0] * l_r[1][1];
    pa_nxt[7] = l_r[2][0] * l_r[0][1];  pb_nxt[7] = l_r[0][0] * l_r[2][1];
    pa_nxt[8] = l_r[0][0] * l_r[1][1];  pb_nxt[8] = l_r[0][1] * l_r[1][0];
  end

  always_comb begin
    for (int m = 0; m < 9; m++) begin
      k_nxt[m] = $signed({pa_r[m][PW-1], pa_r[m]}) - $signed({pb_r[m][PW-1], pb_r[m]});
    end
  end

  // Wide products are split: low 34 bits of a cofactor as an unsigned part,
  // the rest as a signed high part.
  always_comb begin
    logic signed [34:0] klo [9];
    logic signed [32:0] khi [9];
    for (int m = 0; m < 9; m++) begin
      klo[m] = $signed({1'b0, k_r[m][33:0]});
      khi[m] = $signed(k_r[m][KW-1:34]);
    end
    for (int j = 0; j < 3; j++) begin
      dl_nxt[j] = r3_r[j] * klo[3 * j];
      dh_nxt[j] = r3_r[j] * khi[3 * j];
    end
    for (int m = 0; m < 9; m++) begin
      hh_nxt[m] = khi[m] * khi[m];
      hl_nxt[m] = khi[m] * klo[m];
      ll_nxt[m] = k_r[m][33:0] * k_r[m][33:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
      for (int j = 0; j < 3; j++) begin
        r2_r[j] <= l_r[0][j];
        r3_r[j] <= r2_r[j];
      end
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      k_r  <= k_nxt;
      dl_r <= dl_nxt;
      dh_r <= dh_nxt;
      hh_r <= hh_nxt;
      hl_r <= hl_nxt;
      ll_r <= ll_nxt;
      for (int j = 0; j < 3; j++) begin
        dt_r[j] <= {{2{dh_r[j][65]}}, dh_r[j], 34'b0} + {{34{dl_r[j][67]}}, dl_r[j]};
      end
      for (int m = 0; m < 9; m++) begin
        sq_r[m] <= {{2{hh_r[m][65]}}, hh_r[m], 68'b0}
                 + {{33{hl_r[m][67]}}, hl_r[m], 35'b0}
                 + {68'b0, ll_r[m]};
      end
      det6_r <= dt_r[0] + dt_r[1] + dt_r[2];
      for (int g = 0; g < 3; g++) begin
        tg_r[g] <= sq_r[3 * g] + sq_r[3 * g + 1] + sq_r[3 * g + 2];
      end
      det7_r  <= det6_r;
      tr7_r   <= tg_r[0] + tg_r[1] + tg_r[2];
      dpos7_r <= !det6_r[DETW-1] && (det6_r != '0);
    end
  end

  assign det_o = $signed(det7_r);
  assign tr_o  = tr7_r;
  assign ctl_o = '{vld: vld_r[6], dpos: dpos7_r, cap: 1'b0};

endmodule

>>> design/tscu_norm.sv
// Normalisation of the tetrahedron shape check: scales the determinant to
// 32 bits, scales the trace to match, and forms D'^4 and T'^3 from 32x32 parts.
// Seven register stages; depends on tscu_pkg.
module tscu_norm import tscu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  tscu_ctl_t               ctl_i,
  input  logic signed [DETW-1:0]  det_i,
  input  logic [TRW-1:0]          tr_i,
  output tscu_ctl_t               ctl_o,
  output logic [T3W-1:0]          t3_o,
  output logic [D4W-1:0]          d4_o
);

  tscu_ctl_t          ctl_r [7];
  tscu_ctl_t          ctl_nxt [7];
  logic [DETW-1:0]    det1_r, det2_r;
  logic [TRW-1:0]     tr1_r, tr2_r;
  logic [BLW-1:0]     bl_r;
  logic [BLW-1:0]     sh3_r, sh4_r;
  logic [DNW-1:0]     dn_r;
  logic [TNW-1:0]     tn_r, tn4_r, tn5_r;
  logic               big_r;
  logic [63:0]        d2_r;
  logic [63:0]        tpp_r [3][3];
  logic [T2W-1:0]     t2_r;
  logic [63:0]        dpp_r [2][2];
  logic [D4W-1:0]     d4_r, d4b_r;
  logic [63:0]        tpq_r [5][3];
  logic [T3W-1:0]     t3_r;
  logic [15:0]        sh_mul;
  logic [4:0]         sh;
  logic [DETW-1:0]    dsh;
  logic [TRW-1:0]     tsh;
  logic [31:0]        tl [3];
  logic [31:0]        tl5 [3];
  logic [31:0]        t2l [5];
  logic [T2W-1:0]     t2_sum;
  logic [D4W-1:0]     d4_sum;
  logic [T3W-1:0]     t3_sum;

  always_comb begin
    ctl_nxt[0] = ctl_i;
    for (int s = 1; s < 7; s++) ctl_nxt[s] = ctl_r[s-1];
    ctl_nxt[3].cap = big_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 7; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  // Shift count k = ceil((bits - 32) / 3); x / 3 is (x * 171) >> 9 for x < 256.
  always_comb begin
    sh_mul = 16'(bl_r - BLW'(30)) * 16'd171;
    sh     = (bl_r > BLW'(32)) ? sh_mul[13:9] : 5'd0;
    dsh    = det2_r >> sh3_r;
    tsh    = tr2_r >> sh4_r;
  end

  always_comb begin
    tl[0]  = tn_r[31:0];
    tl[1]  = tn_r[63:32];
    tl[2]  = {20'b0, tn_r[75:64]};
    tl5[0] = tn5_r[31:0];
    tl5[1] = tn5_r[63:32];
    tl5[2] = {20'b0, tn5_r[75:64]};
    for (int i = 0; i < 4; i++) begin
      t2l[i] = t2_r[32 * i +: 32];
    end
    t2l[4] = {8'b0, t2_r[T2W-1:128]};
    t2_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t2_sum = t2_sum + (T2W'(tpp_r[i][j]) << (32 * (i + j)));
      end
    end
    d4_sum = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        d4_sum = d4_sum + (D4W'(dpp_r[i][j]) << (32 * (i + j)));
      end
    end
    t3_sum = '0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 3; j++) begin
        t3_sum = t3_sum + (T3W'(tpq_r[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bl_r   <= bit_len(det_i);
      det1_r <= det_i;
      tr1_r  <= tr_i;
      sh3_r  <= BLW'(sh) * BLW'(3);
      sh4_r  <= BLW'(sh) * BLW'(4);
      det2_r <= det1_r;
      tr2_r  <= tr1_r;
      dn_r   <= dsh[DNW-1:0];
      tn_r   <= tsh[TNW-1:0];
      big_r  <= |tsh[TRW-1:TNW];
      d2_r   <= dn_r * dn_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) tpp_r[i][j] <= tl[i] * tl[j];
      end
      tn4_r  <= tn_r;
      t2_r   <= t2_sum;
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) dpp_r[i][j] <= d2_r[32 * i +: 32] * d2_r[32 * j +: 32];
      end
      tn5_r  <= tn4_r;
      d4_r   <= d4_sum;
      for (int i = 0; i < 5; i++) begin
        for (int j = 0; j < 3; j++) tpq_r[i][j] <= t2l[i] * tl5[j];
      end
      d4b_r  <= d4_r;
      t3_r   <= t3_sum;
    end
  end

  assign ctl_o = ctl_r[6];
  assign t3_o  = t3_r;
  assign d4_o  = d4b_r;

endmodule

>>> design/tscu_div.sv
// Restoring divider of the tetrahedron shape check: N = floor(2^48 T'^3 / D'^4),
// one quotient bit per register stage after the input register, with a
// saturation flag for large N. Depends on tscu_pkg.
module tscu_div import tscu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  tscu_ctl_t        ctl_i,
  input  logic [T3W-1:0]   t3_i,
  input  logic [D4W-1:0]   d4_i,
  output tscu_ctl_t        ctl_o,
  output logic [NW-1:0]    n_o
);

  tscu_ctl_t       pctl_r;
  logic [D4W-1:0]  prem_r, pdv_r;
  logic [NW-1:0]   pw_r;
  logic [D4W:0]    top;
  tscu_ctl_t       ctl_r [NW];
  logic [D4W-1:0]  rem_r [NW];
  logic [D4W-1:0]  dv_r [NW];
  logic [NW-1:0]   w_r [NW];
  logic [D4W-1:0]  rem_nxt [NW];
  logic [NW-1:0]   w_nxt [NW];

  assign top = t3_i[T3W-1:T3W-D4W-1];

  // Each step brings down the next dividend bit; the word fills with quotient
  // bits from the bottom as dividend bits leave at the top.
  always_comb begin
    logic [D4W:0]    sft;
    logic [D4W-1:0]  prem;
    logic [NW-1:0]   pw;
    logic [D4W-1:0]  pdv;
    logic            ge;
    for (int k = 0; k < NW; k++) begin
      prem = (k == 0) ? prem_r : rem_r[(k == 0) ? 0 : k - 1];
      pw   = (k == 0) ? pw_r   : w_r[(k == 0) ? 0 : k - 1];
      pdv  = (k == 0) ? pdv_r  : dv_r[(k == 0) ? 0 : k - 1];
      sft  = {prem, pw[NW-1]};
      ge   = sft >= {1'b0, pdv};
      rem_nxt[k] = ge ? D4W'(sft - {1'b0, pdv}) : sft[D4W-1:0];
      w_nxt[k]   = {pw[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pctl_r <= '0;
      for (int k = 0; k < NW; k++) ctl_r[k] <= '0;
    end else if (en) begin
      pctl_r     <= '{vld: ctl_i.vld, dpos: ctl_i.dpos,
                      cap: ctl_i.cap | (top >= {1'b0, d4_i})};
      ctl_r[0]   <= pctl_r;
      for (int k = 1; k < NW; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prem_r <= top[D4W-1:0];
      pdv_r  <= d4_i;
      pw_r   <= {t3_i[T3W-D4W-2:0], 48'b0};
      rem_r  <= rem_nxt;
      w_r    <= w_nxt;
      dv_r[0] <= pdv_r;
      for (int k = 1; k < NW; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  assign ctl_o = ctl_r[NW-1];
  assign n_o   = w_r[NW-1];

endmodule

>>> design/tscu_cbrt.sv
// Integer cube root of the tetrahedron shape check, one result bit per stage.
// Square and cube of the partial root are updated with shifts and adds only.
// Depends on tscu_pkg.
module tscu_cbrt import tscu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  tscu_ctl_t        ctl_i,
  input  logic [NW-1:0]    n_i,
  output tscu_ctl_t        ctl_o,
  output logic [QW-1:0]    root_o
);

  tscu_ctl_t       ctl_r [QW];
  logic [NW-1:0]   n_r [QW];
  logic [QW-1:0]   y_r [QW];
  logic [2*QW-1:0] y2_r [QW];
  logic [NW-1:0]   y3_r [QW];
  logic [QW-1:0]   y_nxt [QW];
  logic [2*QW-1:0] y2_nxt [QW];
  logic [NW-1:0]   y3_nxt [QW];

  // Stage s decides bit 48 - s: (y + 2^b)^3 = y^3 + 3 y^2 2^b + 3 y 2^2b + 2^3b.
  always_comb begin
    logic [CBW-1:0]  py, py2, py3, c3, s2;
    logic [NW-1:0]   pn;
    logic            take;
    for (int s = 0; s < QW; s++) begin
      py  = (s == 0) ? '0 : CBW'(y_r[(s == 0) ? 0 : s - 1]);
      py2 = (s == 0) ? '0 : CBW'(y2_r[(s == 0) ? 0 : s - 1]);
      py3 = (s == 0) ? '0 : CBW'(y3_r[(s == 0) ? 0 : s - 1]);
      pn  = (s == 0) ? n_i : n_r[(s == 0) ? 0 : s - 1];
      c3  = py3 + ((py2 + (py2 << 1)) << (QW - 1 - s))
          + ((py + (py << 1)) << (2 * (QW - 1 - s)))
          + (CBW'(1) << (3 * (QW - 1 - s)));
      s2  = py2 + (py << (QW - s)) + (CBW'(1) << (2 * (QW - 1 - s)));
      take = c3 <= CBW'(pn);
      y_nxt[s]  = take ? (py[QW-1:0] | (QW'(1) << (QW - 1 - s))) : py[QW-1:0];
      y2_nxt[s] = take ? s2[2*QW-1:0] : py2[2*QW-1:0];
      y3_nxt[s] = take ? c3[NW-1:0] : py3[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QW; s++) ctl_r[s] <= '0;
    end else if (en) begin
      ctl_r[0] <= ctl_i;
      for (int s = 1; s < QW; s++) ctl_r[s] <= ctl_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= n_i;
      for (int s = 1; s < QW; s++) n_r[s] <= n_r[s-1];
      y_r  <= y_nxt;
      y2_r <= y2_nxt;
      y3_r <= y3_nxt;
    end
  end

  assign ctl_o  = ctl_r[QW-1];
  assign root_o = y_r[QW-1];

endmodule

>>> design/tetrahedron_shape_check_unit.sv
// Top level of the tetrahedron shape check unit: input skid register, badness
// limit register, the four pipeline sections and the output register.
// Depends on tscu_pkg, tscu_front, tscu_norm, tscu_div and tscu_cbrt.
//
// Each input transaction carries a candidate vertex and the three other
// vertices of a tetrahedron, all signed Q16.16. The unit takes the edge matrix
// from the candidate vertex, its determinant D (six times the signed volume)
// and, when D is positive, the squared Frobenius sum T of the cofactor matrix.
// Badness is T / D^(4/3) - 3 in unsigned Q32.16, clamped at zero and saturated
// at its maximum. The verdict is flipped when D is not positive (badness then
// reads zero), too bad when badness exceeds the limit register times 2^16, and
// acceptable otherwise. One transaction enters the pipeline in every clock
// cycle unless the output is held off, and each produces exactly one result
// transaction, in order. An item passes through 212 register stages: seven
// stages for the determinant and trace, seven for scaling and the wide
// products, a restoring divider (148 stages: an input register, then one
// bit per stage), a cube root with one bit per stage (49 stages) and the
// output register. When the output is held off, the whole pipeline holds;
// one further input transaction is still taken into the skid register,
// after which in_tready falls until the stall clears.
// The limit register is written through the cfg port, which is always ready,
// and should only be changed while no item is in flight.
module tetrahedron_shape_check_unit import tscu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // cand_x, cand_y, cand_z, va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // verdict [1:0], badness [49:2], zero padding [55:50]
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [LIMW-1:0]         cfg_data
);

  logic                    en;
  logic                    skid_v_r;
  logic [IN_TDATA_W-1:0]   skid_d_r;
  logic                    head_vld;
  logic [IN_TDATA_W-1:0]   head_d;
  logic [LIMW-1:0]         limit_r;
  logic                    out_v_r;
  logic [OUT_TDATA_W-1:0]  out_d_r;
  logic [OUT_TDATA_W-1:0]  out_d_nxt;

  tscu_ctl_t               f_ctl, n_ctl, d_ctl, c_ctl;
  logic signed [DETW-1:0]  f_det;
  logic [TRW-1:0]          f_tr;
  logic [T3W-1:0]          n_t3;
  logic [D4W-1:0]          n_d4;
  logic [NW-1:0]           d_n;
  logic [QW-1:0]           c_root;

  logic [QW-1:0]           q;
  logic [BADW-1:0]         bad;
  verdict_t                verdict;

  // The pipeline moves as one whenever the output register is free or drained.
  assign en        = !out_v_r || out_tready;
  assign in_tready = !skid_v_r;
  assign head_vld  = skid_v_r || in_tvalid;
  assign head_d    = skid_v_r ? skid_d_r : in_tdata;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_tvalid && in_tready) begin
      skid_d_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  tscu_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (head_vld),
    .crd_i (head_d),
    .ctl_o (f_ctl),
    .det_o (f_det),
    .tr_o  (f_tr)
  );

  tscu_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (f_ctl),
    .det_i (f_det),
    .tr_i  (f_tr),
    .ctl_o (n_ctl),
    .t3_o  (n_t3),
    .d4_o  (n_d4)
  );

  tscu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (n_ctl),
    .t3_i  (n_t3),
    .d4_i  (n_d4),
    .ctl_o (d_ctl),
    .n_o   (d_n)
  );

  tscu_cbrt u_cbrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (d_ctl),
    .n_i    (d_n),
    .ctl_o  (c_ctl),
    .root_o (c_root)
  );

  // Saturate the root, remove the offset of 3.0 (the value of a right-angled corner with equal edges) and judge.
  always_comb begin
    q   = (c_ctl.cap || (c_root > Q_CAP)) ? Q_CAP : c_root;
    bad = (q > BAD_OFFSET) ? BADW'(q - BAD_OFFSET) : '0;
    if (!c_ctl.dpos) begin
      verdict = VERDICT_FLIP;
      bad     = '0;
    end else if (bad > {limit_r, BAD_FRAC'(0)}) begin
      verdict = VERDICT_BAD;
    end else begin
      verdict = VERDICT_OK;
    end
    out_d_nxt = {(OUT_TDATA_W - BADW - 2)'(0), bad, verdict};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= c_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

>>> design/tscu_checker.sv
// Port-level checks for the tetrahedron shape check unit, bound to the top level.
// Depends on tscu_pkg and tetrahedron_shape_check_unit.
module tscu_checker import tscu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic                    in_tready,
  input  logic                    out_tvalid,
  input  logic                    out_tready,
  input  logic [OUT_TDATA_W-1:0]  out_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_flip_zero_badness: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == VERDICT_FLIP) |-> (out_tdata[BADW+1:2] == '0))
    else $error("flipped result with non-zero badness");

  a_saturated_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == VERDICT_OK) |-> (out_tdata[BADW+1:2] != '1))
    else $error("saturated badness accepted");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after a transaction taken during a stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction changed while stalled");

endmodule

bind tetrahedron_shape_check_unit tscu_checker u_tscu_checker (.*);

>>> tb/sv/tetrahedron_shape_check_unit_test.sv
// Self-checking test of the tetrahedron shape check unit: directed and random
// tetrahedra, limit register changes between phases, and output back-pressure.
// Depends on tscu_pkg and the tetrahedron_shape_check_unit RTL.
`timescale 1ns / 100ps

module tetrahedron_shape_check_unit_test;
  import tscu_pkg::*;

  typedef logic [NCRD-1:0][CW-1:0] tet_t;

  // One expected result transaction.
  typedef struct {
    verdict_t       verdict;
    logic [BADW-1:0] badness;
  } shape_result_t;

  localparam int UNIT = 65536;
  localparam int CMAX = 32'h7FFF_FFFF;
  localparam int CMIN = 32'h8000_0000;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [LIMW-1:0]        cfg_data;

  shape_result_t   shape_queue[$];
  logic [LIMW-1:0] limit_model;
  int              mismatches;
  int              accepted_items;
  int              checked_results;
  int              flip_count;
  int              bad_count;
  int              sat_count;
  bit              send_gaps;
  bit              recv_gaps;
  int              hold_cycles;

  tetrahedron_shape_check_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous fixed limit; a correct run finishes far sooner than this.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", shape_queue.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Computes the expected verdict and badness of one tetrahedron. The
  // determinant and trace are formed exactly; for large determinants both are
  // scaled down so that the cube root search works on bounded operands.
  function automatic shape_result_t predict_shape(input tet_t pt, input logic [LIMW-1:0] lim);
    logic signed [159:0] edge_m[3][3];
    logic signed [159:0] cof[9];
    logic signed [159:0] det;
    logic [159:0]        trace;
    logic [159:0]        det_n;
    logic [159:0]        trace_n;
    logic [319:0]        det4;
    logic [319:0]        rhs;
    logic [319:0]        qtry;
    logic [63:0]         q;
    logic [63:0]         bad;
    int                  dbits;
    int                  tbits;
    int                  sh;
    shape_result_t       res;
    for (int col = 0; col < 3; col++) begin
      for (int row = 0; row < 3; row++) begin
        edge_m[row][col] = 160'($signed(pt[3 + 3 * col + row])) - 160'($signed(pt[row]));
      end
    end
    cof[0] = edge_m[1][1] * edge_m[2][2] - edge_m[1][2] * edge_m[2][1];
    cof[1] = edge_m[0][2] * edge_m[2][1] - edge_m[0][1] * edge_m[2][2];
    cof[2] = edge_m[0][1] * edge_m[1][2] - edge_m[1][1] * edge_m[0][2];
    cof[3] = edge_m[2][0] * edge_m[1][2] - edge_m[1][0] * edge_m[2][2];
    cof[4] = edge_m[0][0] * edge_m[2][2] - edge_m[0][2] * edge_m[2][0];
    cof[5] = edge_m[1][0] * edge_m[0][2] - edge_m[0][0] * edge_m[1][2];
    cof[6] = edge_m[1][0] * edge_m[2][1] - edge_m[2][0] * edge_m[1][1];
    cof[7] = edge_m[2][0] * edge_m[0][1] - edge_m[0][0] * edge_m[2][1];
    cof[8] = edge_m[0][0] * edge_m[1][1] - edge_m[0][1] * edge_m[1][0];
    det = edge_m[0][0] * cof[0] + edge_m[0][1] * cof[3] + edge_m[0][2] * cof[6];
    if (det <= 0) begin
      res.verdict = VERDICT_FLIP;
      res.badness = '0;
      return res;
    end
    trace = '0;
    for (int i = 0; i < 9; i++) trace = trace + 160'(cof[i] * cof[i]);
    dbits = 0;
    for (int i = 0; i < 160; i++) if (det[i]) dbits = i + 1;
    sh = (dbits > 32) ? (dbits - 30) / 3 : 0;
    det_n   = 160'(det) >> (3 * sh);
    trace_n = trace >> (4 * sh);
    tbits = 0;
    for (int i = 0; i < 160; i++) if (trace_n[i]) tbits = i + 1;
    if (tbits > 76) begin
      q = 64'(Q_CAP);
    end else begin
      det4 = 320'(det_n) * 320'(det_n) * 320'(det_n) * 320'(det_n);
      rhs  = (320'(trace_n) * 320'(trace_n) * 320'(trace_n)) << 48;
      // The cube grows with q, so the root is built one bit at a time.
      q = '0;
      for (int b = QW - 1; b >= 0; b--) begin
        qtry = 320'(q | (64'd1 << b));
        if (qtry <= 320'(Q_CAP) && qtry * qtry * qtry * det4 <= rhs) q = 64'(qtry);
      end
    end
    bad = (q > 64'(BAD_OFFSET)) ? q - 64'(BAD_OFFSET) : 64'd0;
    if (bad > 64'hFFFF_FFFF_FFFF) bad = 64'hFFFF_FFFF_FFFF;
    res.badness = bad[BADW-1:0];
    res.verdict = (bad > (64'(lim) << 16)) ? VERDICT_BAD : VERDICT_OK;
    return res;
  endfunction

  function automatic tet_t make_tet(input int px, py, pz, ax, ay, az,
                                    input int bx, by, bz, cx, cy, cz);
    tet_t t;
    t = {cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px};
    return t;
  endfunction

  task automatic report_mismatch(input string what);
    $display("Mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Offers one tetrahedron, with an occasional idle gap before it, and
  // records its expected result once the transaction is accepted.
  task automatic send_tet(input tet_t pt);
    if (send_gaps && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pt;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shape_queue.insert(shape_queue.size(), predict_shape(pt, limit_model));
    accepted_items++;
  endtask

  // Drops valid and waits for every outstanding result and then for the
  // pipeline to empty, so that the limit register can be rewritten safely.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (shape_queue.size() != 0) @(posedge clk);
    repeat (230) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_model = value;
  endtask

  // Random vertex sets: mostly compact shapes with random content, some near
  // degenerate or flipped, and some with coordinates across the full range.
  function automatic tet_t random_tet();
    tet_t t;
    int   span;
    int   centre;
    case ($urandom_range(9))
      0, 1: begin
        for (int i = 0; i < NCRD; i++) t[i] = $urandom;
      end
      2: begin
        // Nearly coplanar: C close to the plane through P, A and B.
        span = $urandom_range(1, 1 << 20);
        for (int i = 0; i < 9; i++) t[i] = $urandom_range(0, span) - span / 2;
        for (int i = 9; i < 12; i++) t[i] = t[i - 6] + t[i - 3] - t[i - 9] + $urandom_range(0, 3) - 1;
      end
      default: begin
        span   = 1 << $urandom_range(2, 24);
        centre = $urandom_range(0, 1 << 26) - (1 << 25);
        t[0] = centre;
        t[1] = centre;
        t[2] = centre;
        for (int i = 3; i < NCRD; i++) t[i] = centre + $urandom_range(0, span) - span / 2;
        // Bias towards the positive orientation so the trace path is exercised.
        if ($urandom_range(3) != 0) begin
          t[3] = centre + span;
          t[7] = centre + span;
          t[11] = centre + span;
        end
      end
    endcase
    return t;
  endfunction

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_tready <= !recv_gaps || ($urandom_range(99) >= 16);
    end
  end

  // Checks every result transaction against the oldest expectation.
  always @(posedge clk) begin
    shape_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (shape_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = shape_queue.pop_front();
        checked_results++;
        if (want.verdict == VERDICT_FLIP) flip_count++;
        if (want.verdict == VERDICT_BAD) bad_count++;
        if (want.badness == 48'hFFFF_FFFF_FFFF) sat_count++;
        if (out_tdata[1:0] !== want.verdict)
          report_mismatch($sformatf("verdict %0d, expected %0d", out_tdata[1:0], want.verdict));
        if (out_tdata[49:2] !== want.badness)
          report_mismatch($sformatf("badness %h, expected %h", out_tdata[49:2], want.badness));
        if (out_tdata[55:50] !== '0)
          report_mismatch($sformatf("padding bits %b not zero", out_tdata[55:50]));
      end
    end
  end

  // Shapes around the reset limit: regular corner, flipped, degenerate,
  // extreme coordinates and a saturating sliver.
  task automatic test_directed_shapes();
    send_tet(make_tet(0, 0, 0, UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT));
    send_tet(make_tet(0, 0, 0, 0, UNIT, 0, UNIT, 0, 0, 0, 0, UNIT));
    send_tet(make_tet(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tet(make_tet(0, 0, 0, UNIT, 0, 0, 2 * UNIT, 0, 0, 0, 0, UNIT));
    send_tet(make_tet(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX));
    send_tet(make_tet(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN));
    send_tet(make_tet(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX));
    send_tet(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 1 << 20, 1 << 20, 1));
    send_tet(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, CMAX, CMAX, 1));
    send_tet(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_tet(make_tet(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_tet(make_tet(5, 7, 11, 5 + UNIT, 7, 11, 5, 7 + UNIT, 11, 5, 7, 11 - UNIT));
    send_tet(make_tet(0, 0, 0, UNIT, 0, 0, UNIT / 2, 56756, 0, UNIT / 2, 18919, 53510));
  endtask

  // The limit register at both extremes and at a low value.
  task automatic test_limit_extremes();
    write_limit('0);
    test_directed_shapes();
    drain_pipeline();
    write_limit('1);
    test_directed_shapes();
    drain_pipeline();
    write_limit(LIMW'(1));
    test_directed_shapes();
    drain_pipeline();
  endtask

  // Random phases, each under a newly written limit, with idling on both sides
  // apart from one stretch where both run flat out.
  task automatic test_random_phases();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: write_limit(LIMW'($urandom_range(0, 4)));
        1: write_limit(LIMW'($urandom_range(0, 1000)));
        default: write_limit($urandom);
      endcase
      send_gaps = (phase != 2);
      recv_gaps = (phase != 2);
      repeat (150) send_tet(random_tet());
      drain_pipeline();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // pipeline fills and in_tready must fall.
  task automatic test_output_hold_off();
    write_limit(LIMIT_RESET);
    hold_cycles = 600;
    repeat (350) send_tet(random_tet());
    drain_pipeline();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    out_tready  = 1'b0;
    hold_cycles = 0;
    send_gaps   = 1'b1;
    recv_gaps   = 1'b1;
    mismatches  = 0;
    limit_model = LIMIT_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_shapes();
    drain_pipeline();
    test_limit_extremes();
    test_random_phases();
    test_output_hold_off();

    $display("Covered %0d tetrahedra under several limits: %0d flipped, %0d too bad, %0d saturated.",
             accepted_items, flip_count, bad_count, sat_count);
    $display("%0d results checked, %0d mismatches.", checked_results, mismatches);
    if (mismatches == 0 && shape_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
